@@ rtl/alt_pkg.sv @@
// package for the address lease table: types, codes and constants
`timescale 1ns / 1ps
`default_nettype none
package alt_pkg;

  localparam int unsigned TableEntriesDefault = 64;
  localparam logic [31:0] LEASE_FOREVER = 32'hFFFF_FFFF;
  localparam logic [31:0] LEASE_SECONDS_RESET = 32'd30;

  typedef enum logic [1:0] {
    REQ_DISCOVER = 2'd0,
    REQ_REQUEST  = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_NONE     = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    REPLY_OFFER = 2'd0,
    REPLY_ACK   = 2'd1,
    REPLY_NACK  = 2'd2,
    REPLY_NONE  = 2'd3
  } reply_type_t;

  typedef enum logic [2:0] {
    REG_POOL_FIRST = 3'd0,
    REG_POOL_LAST  = 3'd1,
    REG_LEASE      = 3'd2,
    REG_RESERVED   = 3'd3,
    REG_RES_VALID  = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE,
    ST_TICK,
    ST_CLEAR
  } alt_state_t;

  typedef enum logic [1:0] {
    OP_DISCOVER,
    OP_REQUEST,
    OP_TICK,
    OP_RESERVE
  } op_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] client_id_high;
    logic [63:0] client_id_low;
    logic [31:0] transaction_id;
    logic [31:0] requested_address;
    logic [31:0] sender_address;
  } alt_in_t;

  typedef struct packed {
    logic [1:0]  reply_type;
    logic [63:0] reply_client_high;
    logic [63:0] reply_client_low;
    logic [31:0] reply_transaction;
    logic [31:0] assigned_address;
    logic        broadcast;
  } alt_out_t;

  // one table row as held in memory
  typedef struct packed {
    logic        valid;
    logic        expired;
    logic [63:0] client_high;
    logic [63:0] client_low;
    logic [31:0] address;
    logic [31:0] remaining;
    logic [15:0] stamp;
  } alt_row_t;

endpackage
`default_nettype wire

@@ rtl/address_lease_table.sv @@
// top level of the address lease table: config registers, scan sequencer and row memory
// discover and request: one scan of the row memory, one entry per cycle, then the decide
//   state, which registers the out_valid strobe
// a tick keeps busy high for a read-modify-write walk of every row; reserve install
//   scans like a discover
// one transfer at a time: no new start is accepted while busy is high; the receiver
//   cannot stall, out_valid is a strobe
// reset: synchronous active-low rst_n clears counters and registers, then a clearing pass
//   with busy high zeroes every row
`timescale 1ns / 1ps
`default_nettype none
module address_lease_table #(
  parameter int unsigned TABLE_ENTRIES = alt_pkg::TableEntriesDefault
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire alt_pkg::alt_in_t  in_data,
  output logic                 out_valid,
  output alt_pkg::alt_out_t    out_data,
  input  wire logic            cfg_psel,
  input  wire logic            cfg_penable,
  input  wire logic            cfg_pwrite,
  input  wire logic [4:0]      cfg_paddr,
  input  wire logic [31:0]     cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import alt_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned FW = 13;

  // configuration registers
  logic [31:0] pool_first_r, pool_last_r, lease_r, reserved_r;
  logic        res_valid_r;

  // control state
  alt_state_t  state_r, state_nxt;
  op_t         op_r;
  alt_in_t     item_r;
  logic [CW-1:0] idx_r;            // read address counter
  logic [CW-1:0] cmp_r;            // index of row currently on read data
  logic          cmp_v_r;
  logic [15:0]  seq_r;
  logic [FW-1:0] fresh_r;
  logic         tick_any_r;

  // scan results
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  alt_row_t      hit_row_r;
  logic          free_f_r;
  logic [IW-1:0] free_idx_r;
  logic          old_f_r;
  logic [IW-1:0] old_idx_r;
  logic [15:0]   old_age_r;
  alt_row_t      old_row_r;

  // row memory, valid and expired flags live in the row
  alt_row_t mem [TABLE_ENTRIES];
  alt_row_t rd_row_r;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wa;
  alt_row_t      wd;

  // output register
  logic     out_valid_r;
  alt_out_t out_r;

  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_POOL_FIRST: cfg_prdata = pool_first_r;
      REG_POOL_LAST:  cfg_prdata = pool_last_r;
      REG_LEASE:      cfg_prdata = lease_r;
      REG_RESERVED:   cfg_prdata = reserved_r;
      REG_RES_VALID:  cfg_prdata = {31'd0, res_valid_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // register writes; reserve install is only issued while idle
  logic reserve_go;
  assign reserve_go = cfg_wr && cfg_paddr[4:2] == REG_RES_VALID && cfg_pwdata[0]
                      && cfg_paddr[1:0] == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_first_r <= '0;
      pool_last_r  <= '0;
      lease_r      <= LEASE_SECONDS_RESET;
      reserved_r   <= '0;
      res_valid_r  <= 1'b0;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
      unique case (cfg_paddr[4:2])
        REG_POOL_FIRST: pool_first_r <= cfg_pwdata;
        REG_POOL_LAST:  pool_last_r  <= cfg_pwdata;
        REG_LEASE:      lease_r      <= cfg_pwdata;
        REG_RESERVED:   reserved_r   <= cfg_pwdata;
        REG_RES_VALID:  res_valid_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // derived values
  logic [31:0] offer_len;
  assign offer_len = (lease_r == LEASE_FOREVER) ? LEASE_FOREVER - 32'd1 : lease_r;

  logic        pool_empty;
  logic [32:0] span_full;
  logic [FW:0] span;
  assign pool_empty = pool_last_r < pool_first_r;
  assign span_full  = {1'b0, pool_last_r} - {1'b0, pool_first_r} + 33'd1;
  assign span = pool_empty ? '0 :
                (span_full > 33'(TABLE_ENTRIES)) ? (FW+1)'(TABLE_ENTRIES) : span_full[FW:0];

  // fresh offset skipping the reserved address
  logic [FW:0]  off0, off;
  logic [31:0]  fresh_addr0;
  assign off0 = {1'b0, fresh_r};
  assign fresh_addr0 = pool_first_r + 32'(off0);
  assign off = (off0 < span && res_valid_r && fresh_addr0 == reserved_r) ? off0 + 1'b1 : off0;

  // scan comparison on the row just read
  logic [IW-1:0] ci;
  logic          row_v, row_e, row_match, row_older;
  logic [15:0]   row_age;
  assign ci        = cmp_r[IW-1:0];
  assign row_v     = rd_row_r.valid;
  assign row_e     = rd_row_r.expired;
  assign row_match = row_v && rd_row_r.client_high == item_r.client_id_high
                     && rd_row_r.client_low == item_r.client_id_low;
  assign row_age   = seq_r - rd_row_r.stamp;
  assign row_older = !old_f_r || row_age > old_age_r ||
                     (row_age == old_age_r &&
                      (rd_row_r.client_high < old_row_r.client_high ||
                       (rd_row_r.client_high == old_row_r.client_high &&
                        rd_row_r.client_low < old_row_r.client_low)));

  // tick update of the row just read
  logic        tick_live, tick_zero;
  logic [31:0] tick_rem;
  assign tick_live = row_v && rd_row_r.remaining != LEASE_FOREVER && rd_row_r.remaining != '0;
  assign tick_rem  = rd_row_r.remaining - 32'd1;
  assign tick_zero = tick_live && tick_rem == '0;

  // ack sum
  logic [32:0] ack_sum;
  logic [31:0] ack_rem;
  assign ack_sum = {1'b0, hit_row_r.remaining} + {1'b0, lease_r};
  assign ack_rem = (hit_row_r.remaining == LEASE_FOREVER) ? LEASE_FOREVER :
                   (ack_sum > {1'b0, LEASE_FOREVER - 32'd1}) ? LEASE_FOREVER - 32'd1 :
                   ack_sum[31:0];

  logic in_pool;
  assign in_pool = !pool_empty && item_r.requested_address >= pool_first_r
                   && item_r.requested_address <= pool_last_r;

  // decision made in ST_DECIDE
  logic          dec_write, dec_reply, dec_fresh;
  logic [IW-1:0] dec_idx;
  alt_row_t      dec_row;
  logic          dec_clear_exp;
  alt_out_t      dec_out;

  always_comb begin
    dec_write     = 1'b0;
    dec_reply     = 1'b0;
    dec_fresh     = 1'b0;
    dec_idx       = hit_idx_r;
    dec_row       = hit_row_r;
    dec_clear_exp = 1'b0;
    dec_out.reply_type        = REPLY_OFFER;
    dec_out.reply_client_high = item_r.client_id_high;
    dec_out.reply_client_low  = item_r.client_id_low;
    dec_out.reply_transaction = item_r.transaction_id;
    dec_out.assigned_address  = item_r.requested_address;
    dec_out.broadcast         = item_r.sender_address != item_r.requested_address;
    unique case (op_r)
      OP_DISCOVER: begin
        dec_out.broadcast = 1'b1;
        if (hit_r) begin
          dec_write = 1'b1; dec_reply = 1'b1; dec_clear_exp = 1'b1;
          dec_row.remaining = offer_len;
          dec_out.assigned_address = hit_row_r.address;
        end else if (off < span) begin
          if (free_f_r) begin
            dec_write = 1'b1; dec_reply = 1'b1; dec_fresh = 1'b1; dec_clear_exp = 1'b1;
            dec_idx = free_idx_r;
            dec_row.client_high = item_r.client_id_high;
            dec_row.client_low  = item_r.client_id_low;
            dec_row.address     = pool_first_r + 32'(off);
            dec_row.remaining   = offer_len;
            dec_row.stamp       = '0;
            dec_out.assigned_address = pool_first_r + 32'(off);
          end
        end else if (old_f_r) begin
          dec_write = 1'b1; dec_reply = 1'b1; dec_clear_exp = 1'b1;
          dec_idx = old_idx_r;
          dec_row.client_high = item_r.client_id_high;
          dec_row.client_low  = item_r.client_id_low;
          dec_row.address     = old_row_r.address;
          dec_row.remaining   = offer_len;
          dec_row.stamp       = '0;
          dec_out.assigned_address = old_row_r.address;
        end
      end
      OP_REQUEST: begin
        if (in_pool) begin
          dec_reply = 1'b1;
          if (hit_r) begin
            dec_write = 1'b1; dec_clear_exp = 1'b1;
            dec_row.remaining = ack_rem;
            dec_out.reply_type = REPLY_ACK;
          end else begin
            dec_out.reply_type = REPLY_NACK;
          end
        end
      end
      OP_RESERVE: begin
        dec_idx = hit_r ? hit_idx_r : free_idx_r;
        dec_write = hit_r || free_f_r;
        dec_clear_exp = 1'b1;
        dec_row.client_high = '0;
        dec_row.client_low  = '0;
        dec_row.address     = reserved_r;
        dec_row.remaining   = LEASE_FOREVER;
        dec_row.stamp       = '0;
      end
      default: ;
    endcase
    // a written row is always a live lease
    dec_row.valid = 1'b1;
    if (dec_clear_exp) dec_row.expired = 1'b0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_data.req_type == REQ_TICK) begin
          state_nxt = ST_TICK;
        end else if (start && (in_data.req_type == REQ_DISCOVER
                               || in_data.req_type == REQ_REQUEST)) begin
          state_nxt = ST_SCAN;
        end else if (reserve_go) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN:   if (cmp_v_r && cmp_r == CW'(TABLE_ENTRIES - 1)) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_IDLE;
      ST_TICK:   if (cmp_v_r && cmp_r == CW'(TABLE_ENTRIES - 1)) state_nxt = ST_IDLE;
      ST_CLEAR:  if (idx_r == CW'(TABLE_ENTRIES - 1)) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory write port select
  always_comb begin
    we = 1'b0;
    wa = dec_idx;
    wd = dec_row;
    if (state_r == ST_CLEAR) begin
      // clearing pass after reset, one row per cycle
      we = 1'b1;
      wa = idx_r[IW-1:0];
      wd = '0;
    end else if (state_r == ST_DECIDE) begin
      we = dec_write;
    end else if (state_r == ST_TICK && cmp_v_r && tick_live) begin
      we = 1'b1;
      wa = ci;
      wd = rd_row_r;
      wd.remaining = tick_rem;
      if (tick_zero) begin
        wd.stamp   = seq_r;
        wd.expired = 1'b1;
      end
    end
  end

  // row 0 is read while idle so a scan can start at once
  assign rd_addr = (state_r == ST_IDLE || idx_r == CW'(TABLE_ENTRIES)) ? '0 : idx_r[IW-1:0];

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_row_r <= mem[rd_addr];
  end

  // control and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      op_r        <= OP_DISCOVER;
      idx_r       <= '0;
      cmp_r       <= '0;
      cmp_v_r     <= 1'b0;
      seq_r       <= '0;
      fresh_r     <= '0;
      tick_any_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_f_r    <= 1'b0;
      old_f_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          idx_r <= idx_r + 1'b1;
        end
        ST_IDLE: begin
          hit_r    <= 1'b0;
          free_f_r <= 1'b0;
          old_f_r  <= 1'b0;
          tick_any_r <= 1'b0;
          if (state_nxt != ST_IDLE) begin
            idx_r <= CW'(1);
            cmp_r <= '0;
            cmp_v_r <= 1'b1;
            priority if (start && in_data.req_type == REQ_TICK) begin
              op_r <= OP_TICK;
              item_r <= in_data;
            end else if (start && in_data.req_type == REQ_DISCOVER) begin
              op_r <= OP_DISCOVER;
              item_r <= in_data;
            end else if (start && in_data.req_type == REQ_REQUEST) begin
              op_r <= OP_REQUEST;
              item_r <= in_data;
            end else begin
              // reserve install scans for the all-zero client id
              op_r <= OP_RESERVE;
              item_r <= '0;
            end
          end else begin
            idx_r   <= '0;
            cmp_v_r <= 1'b0;
          end
        end
        ST_SCAN, ST_TICK: begin
          // idx_r leads cmp_r by one: read data of row cmp_r is on rd_row_r
          if (cmp_v_r) begin
            if (idx_r != CW'(TABLE_ENTRIES)) idx_r <= idx_r + 1'b1;
            cmp_r <= cmp_r + 1'b1;
            if (cmp_r == CW'(TABLE_ENTRIES - 1)) cmp_v_r <= 1'b0;
          end
          if (state_r == ST_SCAN && cmp_v_r) begin
            if (row_match && !hit_r) begin
              hit_r <= 1'b1; hit_idx_r <= ci; hit_row_r <= rd_row_r;
            end
            if (!row_v && !free_f_r) begin
              free_f_r <= 1'b1; free_idx_r <= ci;
            end
            if (row_v && row_e && row_older) begin
              old_f_r <= 1'b1; old_idx_r <= ci; old_age_r <= row_age; old_row_r <= rd_row_r;
            end
          end
          if (state_r == ST_TICK && cmp_v_r && tick_zero)
            tick_any_r <= 1'b1;
          if (state_r == ST_TICK && state_nxt == ST_IDLE && (tick_any_r || (cmp_v_r && tick_zero)))
            seq_r <= seq_r + 16'd1;
        end
        ST_DECIDE: begin
          if (dec_fresh) fresh_r <= FW'(off + 1'b1);
          out_valid_r <= dec_reply;
          out_r <= dec_out;
        end
        default: ;
      endcase
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a reply only leaves the decide step
  a_reply_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_DECIDE)
    else $error("reply outside decide step");

  // a reply never starts while a tick walks the table
  a_no_reply_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |=> !out_valid)
    else $error("reply during tick");

  // the read pointer leads the compare pointer by one while scanning
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cmp_v_r) |-> idx_r == cmp_r + 1'b1)
    else $error("scan pointers out of step");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// self-checking bench for the address lease table: directed rows then random traffic
`timescale 1ns / 1ps
module tb_top;
  import alt_pkg::*;

  localparam int Entries = 64;
  localparam int SettleCycles = Entries + 8;  // a tick makes no reply but keeps the table busy
  localparam int WatchdogLimit = 4000;
  localparam int ExpDepth = 512;
  localparam int RowDepth = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  alt_in_t in_data = '0;
  logic out_valid;
  alt_out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always #4 clk = ~clk;

  address_lease_table #(.TABLE_ENTRIES(Entries)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // shadow of the config registers
  logic [31:0] pool_first, pool_last, lease_len, own_addr;
  logic        own_held;

  // shadow of the lease table
  logic        lt_valid [Entries];
  logic        lt_lapsed[Entries];
  logic [63:0] lt_hi    [Entries];
  logic [63:0] lt_lo    [Entries];
  logic [31:0] lt_addr  [Entries];
  logic [31:0] lt_left  [Entries];
  logic [15:0] lt_stamp [Entries];
  logic [15:0] lapse_seq;
  logic [31:0] fresh_next;

  // expected replies in order, written by the sender and read by the checker
  alt_out_t exp_fifo[ExpDepth];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int idle_cycles = 0;

  // client ids drawn from per phase, so the same clients come back
  logic [63:0] pool_hi[96];
  logic [63:0] pool_lo[96];

  function automatic int find_client(logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < Entries; i++)
      if (lt_valid[i] && lt_hi[i] == hi && lt_lo[i] == lo) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < Entries; i++)
      if (!lt_valid[i]) return i;
    return -1;
  endfunction

  // oldest lapsed lease; equal age goes to the smaller client id
  function automatic int oldest_lapsed();
    int best;
    logic [15:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < Entries; i++) begin
      if (!lt_valid[i] || !lt_lapsed[i]) continue;
      age = lapse_seq - lt_stamp[i];
      if (best < 0 || age > best_age || (age == best_age && (lt_hi[i] < lt_hi[best] ||
          (lt_hi[i] == lt_hi[best] && lt_lo[i] < lt_lo[best])))) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic void fill_row(int s, logic [63:0] hi, logic [63:0] lo,
                                   logic [31:0] addr, logic [31:0] left);
    lt_valid[s] = 1'b1;
    lt_hi[s] = hi;
    lt_lo[s] = lo;
    lt_addr[s] = addr;
    lt_left[s] = left;
    lt_lapsed[s] = 1'b0;
    lt_stamp[s] = '0;
  endfunction

  function automatic void reset_shadow();
    pool_first = '0;
    pool_last = '0;
    lease_len = LEASE_SECONDS_RESET;
    own_addr = '0;
    own_held = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      lt_valid[i] = 1'b0;
      lt_lapsed[i] = 1'b0;
      lt_hi[i] = '0;
      lt_lo[i] = '0;
      lt_addr[i] = '0;
      lt_left[i] = '0;
      lt_stamp[i] = '0;
    end
    lapse_seq = '0;
    fresh_next = '0;
  endfunction

  function automatic void shadow_config(reg_index_t idx, logic [31:0] val);
    int s;
    case (idx)
      REG_POOL_FIRST: pool_first = val;
      REG_POOL_LAST:  pool_last = val;
      REG_LEASE:      lease_len = val;
      REG_RESERVED:   own_addr = val;
      REG_RES_VALID: begin
        own_held = val[0];
        // holding the own address installs the all-zero client permanently
        if (own_held) begin
          s = find_client('0, '0);
          if (s < 0) s = first_free();
          if (s >= 0) fill_row(s, '0, '0, own_addr, LEASE_FOREVER);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] fresh_span();
    logic [32:0] span;
    if (pool_last < pool_first) return 0;
    span = {1'b0, pool_last} - {1'b0, pool_first} + 33'd1;
    if (span > Entries) span = Entries;
    return span[31:0];
  endfunction

  // expected reply for one transfer; returns 0 when no reply is due
  function automatic bit lease_predict(alt_in_t it, output alt_out_t rep);
    logic [31:0] offer_len, off, addr, span;
    logic [32:0] sum;
    int s;
    bit any;
    rep = '0;
    offer_len = (lease_len == LEASE_FOREVER) ? LEASE_FOREVER - 1 : lease_len;
    case (req_type_t'(it.req_type))
      REQ_DISCOVER: begin
        s = find_client(it.client_id_high, it.client_id_low);
        if (s >= 0) begin
          // known client keeps its address, even a permanent one is reset
          lt_lapsed[s] = 1'b0;
          lt_left[s] = offer_len;
          addr = lt_addr[s];
        end else begin
          span = fresh_span();
          off = fresh_next;
          if (off < span && own_held && pool_first + off == own_addr) off++;
          if (off < span) begin
            s = first_free();
            if (s < 0) return 1'b0;
            addr = pool_first + off;
            fresh_next = off + 1;
          end else begin
            s = oldest_lapsed();
            if (s < 0) return 1'b0;
            addr = lt_addr[s];
          end
          fill_row(s, it.client_id_high, it.client_id_low, addr, offer_len);
        end
        rep = {REPLY_OFFER, it.client_id_high, it.client_id_low, it.transaction_id,
               addr, 1'b1};
        return 1'b1;
      end
      REQ_REQUEST: begin
        if (pool_last < pool_first || it.requested_address < pool_first ||
            it.requested_address > pool_last) return 1'b0;
        s = find_client(it.client_id_high, it.client_id_low);
        if (s >= 0) begin
          if (lt_left[s] != LEASE_FOREVER) begin
            sum = {1'b0, lt_left[s]} + {1'b0, lease_len};
            if (sum > {1'b0, LEASE_FOREVER - 32'd1}) sum = {1'b0, LEASE_FOREVER - 32'd1};
            lt_left[s] = sum[31:0];
          end
          lt_lapsed[s] = 1'b0;
        end
        rep = {(s >= 0) ? REPLY_ACK : REPLY_NACK, it.client_id_high, it.client_id_low,
               it.transaction_id, it.requested_address,
               it.sender_address != it.requested_address};
        return 1'b1;
      end
      REQ_TICK: begin
        any = 1'b0;
        for (int i = 0; i < Entries; i++) begin
          if (!lt_valid[i] || lt_left[i] == LEASE_FOREVER || lt_left[i] == 0) continue;
          lt_left[i]--;
          if (lt_left[i] == 0) begin
            lt_lapsed[i] = 1'b1;
            lt_stamp[i] = lapse_seq;
            any = 1'b1;
          end
        end
        if (any) lapse_seq++;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // apb write: setup cycle then access cycle
  task automatic cfg_write(reg_index_t idx, logic [31:0] val);
    @(negedge clk);
    // the table clears itself after reset and a reserve install scans it
    while (busy) @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    shadow_config(idx, val);
    // reserve install runs its own scan
    while (busy) @(negedge clk);
  endtask

  // stop sending and let every reply and any silent tick finish
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // one transfer; start stays high until accepted, lowered only after a gap
  task automatic send_item(alt_in_t it, bit typed, bit typed_has, alt_out_t typed_rep);
    int gap;
    bit has;
    alt_out_t rep;
    gap = $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = it;
    start = 1'b1;
    do @(posedge clk); while (busy);
    has = lease_predict(it, rep);
    if (typed) begin
      has = typed_has;
      rep = typed_rep;
    end
    if (has) begin
      exp_fifo[exp_wr] = rep;
      exp_wr++;
    end
  endtask

  function automatic alt_in_t mk_in(req_type_t ty, logic [63:0] hi, logic [63:0] lo,
                                    logic [31:0] tr, logic [31:0] rq, logic [31:0] snd);
    return {ty, hi, lo, tr, rq, snd};
  endfunction

  function automatic alt_out_t mk_out(reply_type_t ty, logic [63:0] hi, logic [63:0] lo,
                                      logic [31:0] tr, logic [31:0] addr, logic bc);
    return {ty, hi, lo, tr, addr, bc};
  endfunction

  typedef struct {
    alt_in_t  item;
    bit       typed;
    bit       replies;
    alt_out_t reply;
  } stim_row_t;

  stim_row_t rows[RowDepth];
  int n_rows = 0;

  function automatic void add_row(alt_in_t it, bit typed, bit replies, alt_out_t rep);
    rows[n_rows].item = it;
    rows[n_rows].typed = typed;
    rows[n_rows].replies = replies;
    rows[n_rows].reply = rep;
    n_rows++;
  endfunction

  // directed rows for pool 100..103, lease 2, own address 101 held
  function automatic void build_rows();
    logic [63:0] ones;
    ones = '1;
    // fresh addresses start at the pool base
    add_row(mk_in(REQ_DISCOVER, 1, 1, 32'h11, 0, 0), 1'b1, 1'b1,
            mk_out(REPLY_OFFER, 1, 1, 32'h11, 100, 1'b1));
    // the own address is skipped
    add_row(mk_in(REQ_DISCOVER, ones, ones, '1, '1, '1), 1'b1, 1'b1,
            mk_out(REPLY_OFFER, ones, ones, '1, 102, 1'b1));
    // sender equals requested address gives a unicast ack
    add_row(mk_in(REQ_REQUEST, 1, 1, 32'h22, 100, 100), 1'b1, 1'b1,
            mk_out(REPLY_ACK, 1, 1, 32'h22, 100, 1'b0));
    // unknown client
    add_row(mk_in(REQ_REQUEST, 2, 2, 32'h33, 103, 0), 1'b1, 1'b1,
            mk_out(REPLY_NACK, 2, 2, 32'h33, 103, 1'b1));
    // outside the pool: silent
    add_row(mk_in(REQ_REQUEST, 1, 1, 32'h44, 104, 104), 1'b1, 1'b0, '0);
    add_row(mk_in(REQ_DISCOVER, 2, 2, 32'h55, 0, 0), 1'b1, 1'b1,
            mk_out(REPLY_OFFER, 2, 2, 32'h55, 103, 1'b1));
    // pool used up and nothing lapsed: silent
    add_row(mk_in(REQ_DISCOVER, 3, 3, 32'h66, 0, 0), 1'b1, 1'b0, '0);
    // two ticks lapse both two-tick leases in one go
    add_row(mk_in(REQ_TICK, 0, 0, 0, 0, 0), 1'b1, 1'b0, '0);
    add_row(mk_in(REQ_TICK, ones, ones, '1, '1, '1), 1'b1, 1'b0, '0);
    // reclaim oldest lapsed, smaller id first on a tie
    add_row(mk_in(REQ_DISCOVER, 3, 3, 32'h77, 0, 0), 1'b0, 1'b0, '0);
    add_row(mk_in(REQ_DISCOVER, 4, 4, 32'h88, 0, 0), 1'b0, 1'b0, '0);
    add_row(mk_in(REQ_NONE, 5, 5, 32'h99, 100, 100), 1'b1, 1'b0, '0);
    // known client keeps its address
    add_row(mk_in(REQ_DISCOVER, 1, 1, 32'haa, 0, 0), 1'b0, 1'b0, '0);
    // permanent lease stays permanent on ack
    add_row(mk_in(REQ_REQUEST, 0, 0, 32'hbb, 101, 101), 1'b0, 1'b0, '0);
    add_row(mk_in(REQ_TICK, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0);
    add_row(mk_in(REQ_DISCOVER, 0, 0, 32'hcc, 0, 0), 1'b0, 1'b0, '0);
    add_row(mk_in(REQ_REQUEST, 3, 3, 32'hdd, 103, 7), 1'b0, 1'b0, '0);
  endfunction

  function automatic alt_in_t random_item(int n_clients);
    alt_in_t it;
    int roll, k;
    logic [31:0] span;
    roll = $urandom_range(0, 99);
    it.req_type = roll < 38 ? REQ_DISCOVER : roll < 70 ? REQ_REQUEST :
                  roll < 95 ? REQ_TICK : REQ_NONE;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      it.client_id_high = '0;
      it.client_id_low = '0;
    end else if (roll < 10) begin
      it.client_id_high = {$urandom, $urandom};
      it.client_id_low = {$urandom, $urandom};
    end else begin
      k = $urandom_range(0, n_clients - 1);
      it.client_id_high = pool_hi[k];
      it.client_id_low = pool_lo[k];
    end
    it.transaction_id = $urandom;
    span = fresh_span();
    if ($urandom_range(0, 99) < 80)
      it.requested_address = pool_first + $urandom_range(0, span + 1);
    else
      it.requested_address = $urandom;
    it.sender_address = $urandom_range(0, 1) ? it.requested_address : $urandom;
    return it;
  endfunction

  // reply checker
  always @(posedge clk) begin
    alt_out_t want;
    if (out_valid) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: reply exp none got %h", $time, out_data);
        errors++;
      end else begin
        want = exp_fifo[exp_rd];
        exp_rd++;
        if (out_data.reply_type !== want.reply_type) begin
          $display("%0t: reply_type exp %0d got %0d", $time, want.reply_type,
                   out_data.reply_type);
          errors++;
        end
        if (out_data.reply_client_high !== want.reply_client_high) begin
          $display("%0t: reply_client_high exp %h got %h", $time, want.reply_client_high,
                   out_data.reply_client_high);
          errors++;
        end
        if (out_data.reply_client_low !== want.reply_client_low) begin
          $display("%0t: reply_client_low exp %h got %h", $time, want.reply_client_low,
                   out_data.reply_client_low);
          errors++;
        end
        if (out_data.reply_transaction !== want.reply_transaction) begin
          $display("%0t: reply_transaction exp %h got %h", $time, want.reply_transaction,
                   out_data.reply_transaction);
          errors++;
        end
        if (out_data.assigned_address !== want.assigned_address) begin
          $display("%0t: assigned_address exp %h got %h", $time, want.assigned_address,
                   out_data.assigned_address);
          errors++;
        end
        if (out_data.broadcast !== want.broadcast) begin
          $display("%0t: broadcast exp %b got %b", $time, want.broadcast,
                   out_data.broadcast);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // phase settings: pool first, pool last, lease, own address, held, client count
  logic [31:0] ph_first[6] = '{0, 32'hFFFF_FFF8, 50, 0, 1000, 0};
  logic [31:0] ph_last [6] = '{63, 32'hFFFF_FFFF, 10, 3, 1040, 32'hFFFF_FFFF};
  logic [31:0] ph_lease[6] = '{3, 1, 7, 2, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
  logic [31:0] ph_own  [6] = '{200, 32'hFFFF_FFFA, 0, 0, 1005, 5};
  logic        ph_held [6] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
  int          ph_nclt [6] = '{80, 14, 10, 10, 20, 12};

  initial begin
    reset_shadow();
    build_rows();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    cfg_write(REG_POOL_FIRST, 100);
    cfg_write(REG_POOL_LAST, 103);
    cfg_write(REG_LEASE, 2);
    cfg_write(REG_RESERVED, 101);
    cfg_write(REG_RES_VALID, 1);
    for (int i = 0; i < n_rows; i++)
      send_item(rows[i].item, rows[i].typed, rows[i].replies, rows[i].reply);

    for (int p = 0; p < 6; p++) begin
      drain();
      // clearing the held flag first exercises a write of zero
      cfg_write(REG_RES_VALID, 0);
      cfg_write(REG_POOL_FIRST, ph_first[p]);
      cfg_write(REG_POOL_LAST, ph_last[p]);
      cfg_write(REG_LEASE, ph_lease[p]);
      cfg_write(REG_RESERVED, ph_own[p]);
      cfg_write(REG_RES_VALID, {31'd0, ph_held[p]});
      for (int k = 0; k < 96; k++) begin
        pool_hi[k] = {$urandom, $urandom};
        pool_lo[k] = {$urandom, $urandom};
      end
      for (int n = 0; n < 72; n++) begin
        // hold off once mid-phase until the replies have all come back
        if (p == 1 && n == 36) drain();
        send_item(random_item(ph_nclt[p]), 1'b0, 1'b0, '0);
      end
    end

    drain();
    repeat (SettleCycles) @(negedge clk);
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
